>>> hdl/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

   // Store geometry
   localparam int STORE_DEPTH  = 4096;
   localparam int ADDR_W       = 12;
   localparam int GRID_SIZE_DEF = 64;

   // Field widths
   localparam int POS_W        = 32;
   localparam int HEIGHT_W     = 32;
   localparam int SLOPE_W      = 16;
   localparam int SCALE_W      = 24;
   localparam int AMP_W        = 16;
   localparam int WORD_W       = 32;
   localparam int FRAC_W       = 16;
   localparam int CODE_W       = 11;

   // Configuration port
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_Z     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_BITS = 3'd4;

   localparam logic [SCALE_W-1:0] GRID_SCALE_RST = 24'h01_0000;
   localparam logic [AMP_W-1:0]   AMPLITUDE_RST  = 16'h1000;

   // Opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      logic                       opcode;
      logic [ADDR_W-1:0]          texel_index;
      logic signed [HEIGHT_W-1:0] texel_height;
      logic signed [SLOPE_W-1:0]  texel_slope_x;
      logic signed [SLOPE_W-1:0]  texel_slope_z;
      logic signed [POS_W-1:0]    pos_x;
      logic signed [POS_W-1:0]    pos_y;
      logic signed [POS_W-1:0]    pos_z;
   } req_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [POS_W-1:0] out_z;
      logic [WORD_W-1:0]       normal_word;
   } rsp_item_type;

   typedef struct packed {
      logic signed [HEIGHT_W-1:0] height;
      logic signed [SLOPE_W-1:0]  slope_x;
      logic signed [SLOPE_W-1:0]  slope_z;
   } texel_type;

endpackage

`default_nettype wire

>>> hdl/hbs_if.sv
`default_nettype none

interface hbs_req_if;
   import hbs_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface hbs_rsp_if;
   import hbs_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> hdl/hbs_ram.sv
`default_nettype none

module hbs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Hold read data while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

>>> hdl/hbs_lerp_lane.sv
`default_nettype none

// Six-stage bilinear blend of four corners, floor of the exact weighted sum.
module hbs_lerp_lane #(
   parameter int DATA_W = 16
) (
   input  logic                        clock,
   input  logic                        enable,
   input  logic signed [DATA_W-1:0]    corner_a1,
   input  logic signed [DATA_W-1:0]    corner_a2,
   input  logic signed [DATA_W-1:0]    corner_a3,
   input  logic signed [DATA_W-1:0]    corner_a4,
   input  logic [hbs_pkg::FRAC_W-1:0]  frac_x,
   input  logic [hbs_pkg::FRAC_W-1:0]  frac_z,
   output logic signed [DATA_W-1:0]    result
);
   import hbs_pkg::*;

   localparam int D_W   = DATA_W + 1;
   localparam int M_W   = DATA_W + FRAC_W + 1;
   localparam int R_W   = DATA_W + FRAC_W;
   localparam int DZ_W  = R_W + 1;
   localparam int MZ_W  = DZ_W + FRAC_W + 1;

   // stage 1: horizontal differences
   logic signed [D_W-1:0]    l1_d0_ff, l1_d1_ff;
   logic signed [DATA_W-1:0] l1_a1_ff, l1_a3_ff;
   logic [FRAC_W-1:0]        l1_fx_ff, l1_fz_ff;
   // stage 2: horizontal products
   logic signed [M_W-1:0]    l2_m0_ff, l2_m1_ff;
   logic signed [DATA_W-1:0] l2_a1_ff, l2_a3_ff;
   logic [FRAC_W-1:0]        l2_fz_ff;
   // stage 3: row values
   logic signed [R_W-1:0]    l3_r0_ff, l3_r1_ff;
   logic [FRAC_W-1:0]        l3_fz_ff;
   // stage 4: vertical difference
   logic signed [DZ_W-1:0]   l4_dz_ff;
   logic signed [R_W-1:0]    l4_r0_ff;
   logic [FRAC_W-1:0]        l4_fz_ff;
   // stage 5: vertical product
   logic signed [MZ_W-1:0]   l5_mz_ff;
   logic signed [R_W-1:0]    l5_r0_ff;
   // stage 6: result
   logic signed [DATA_W-1:0] l6_result_ff;

   logic signed [M_W-1:0]    m0_in, m1_in, r0_in, r1_in;
   logic signed [MZ_W-1:0]   mz_in, tot_in;

   always_comb begin
      m0_in  = M_W'(l1_d0_ff) * M_W'($signed({1'b0, l1_fx_ff}));
      m1_in  = M_W'(l1_d1_ff) * M_W'($signed({1'b0, l1_fx_ff}));
      r0_in  = (M_W'(l2_a1_ff) <<< FRAC_W) + l2_m0_ff;
      r1_in  = (M_W'(l2_a3_ff) <<< FRAC_W) + l2_m1_ff;
      mz_in  = MZ_W'(l4_dz_ff) * MZ_W'($signed({1'b0, l4_fz_ff}));
      tot_in = (MZ_W'(l5_r0_ff) <<< FRAC_W) + l5_mz_ff;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         l1_d0_ff     <= D_W'(corner_a2) - D_W'(corner_a1);
         l1_d1_ff     <= D_W'(corner_a4) - D_W'(corner_a3);
         l1_a1_ff     <= corner_a1;
         l1_a3_ff     <= corner_a3;
         l1_fx_ff     <= frac_x;
         l1_fz_ff     <= frac_z;

         l2_m0_ff     <= m0_in;
         l2_m1_ff     <= m1_in;
         l2_a1_ff     <= l1_a1_ff;
         l2_a3_ff     <= l1_a3_ff;
         l2_fz_ff     <= l1_fz_ff;

         l3_r0_ff     <= R_W'(r0_in);
         l3_r1_ff     <= R_W'(r1_in);
         l3_fz_ff     <= l2_fz_ff;

         l4_dz_ff     <= DZ_W'(l3_r1_ff) - DZ_W'(l3_r0_ff);
         l4_r0_ff     <= l3_r0_ff;
         l4_fz_ff     <= l3_fz_ff;

         l5_mz_ff     <= mz_in;
         l5_r0_ff     <= l4_r0_ff;

         // drop the 32 weight fraction bits: floor of the weighted sum
         l6_result_ff <= tot_in[2*FRAC_W +: DATA_W];
      end
   end

   assign result = l6_result_ff;

endmodule

`default_nettype wire

>>> hdl/wrapped_bilinear_heightfield_sampler_unit.sv
`default_nettype none

// Channel   Dir  Handshake        Payload
// -------   ---  ---------------  --------------------------------------------
// req_chan  in   valid / ready    opcode, texel load data, sample position
// rsp_chan  out  valid / ready    out_x, out_y, out_z, normal_word
// csr_*     in   csr_we (no wait) csr_index, csr_wdata
//
// One item enters per cycle while the pipeline is not held; a sample result
// shows on rsp_chan. Load items write the texel stores and give no result.
// The whole pipeline advances together and holds when the output register is
// full and not taken; req_chan.ready follows that hold.
// Reset clears the valid bits and the configuration registers. The texel
// stores are not cleared: load every texel before sampling it.
module wrapped_bilinear_heightfield_sampler_unit #(
   parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   hbs_req_if.sink                         req_chan,
   hbs_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [hbs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hbs_pkg::*;

   // Grid index width and wrap mask (AND with GRID_SIZE - 1)
   localparam int            XW   = $clog2(GRID_SIZE);
   localparam logic [XW-1:0] WRAP = XW'(GRID_SIZE - 1);

   localparam int SUM_W   = POS_W + 1;
   localparam int PROD_W  = SUM_W + SCALE_W + 1;
   localparam int UV_W    = FRAC_W + XW;
   localparam int TEXEL_W = $bits(texel_type);
   localparam int LANE_DEPTH = 6;           // register levels inside a blend lane
   localparam int HM_W    = HEIGHT_W + AMP_W + 1;
   localparam int SM_W    = SLOPE_W + AMP_W + 1;
   localparam int YS_W    = HM_W - 12 + 1;  // height gain is Q4.12
   localparam int CS_W    = SM_W - FRAC_W + 1;
   localparam logic [WORD_W-1:0] UNUSED_CODE_BITS = 32'hF800_F800;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic signed [POS_W-1:0] move_x_ff, move_z_ff;
   logic [SCALE_W-1:0]      grid_scale_ff;
   logic [AMP_W-1:0]        amplitude_ff;
   logic [WORD_W-1:0]       alpha_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         move_x_ff     <= '0;
         move_z_ff     <= '0;
         grid_scale_ff <= GRID_SCALE_RST;
         amplitude_ff  <= AMPLITUDE_RST;
         alpha_bits_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MOVE_X:     move_x_ff     <= csr_wdata;
            CSR_MOVE_Z:     move_z_ff     <= csr_wdata;
            CSR_GRID_SCALE: grid_scale_ff <= csr_wdata[SCALE_W-1:0];
            CSR_AMPLITUDE:  amplitude_ff  <= csr_wdata[AMP_W-1:0];
            CSR_ALPHA_BITS: alpha_bits_ff <= csr_wdata;
            default: ;      // unknown index: ignore
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline control: advance everything unless the result is held
   // ---------------------------------------------------------------------
   logic         advance;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // ---------------------------------------------------------------------
   // Stage 1: capture item, add the offsets
   // ---------------------------------------------------------------------
   logic                     p1_valid_ff;
   logic                     p1_op_ff;
   logic [ADDR_W-1:0]        p1_index_ff;
   texel_type                p1_texel_ff;
   logic signed [SUM_W-1:0]  p1_ax_ff, p1_az_ff;
   logic signed [POS_W-1:0]  p1_px_ff, p1_py_ff, p1_pz_ff;

   // ---------------------------------------------------------------------
   // Stage 2: scale into texel units, keep fraction and low integer bits
   // ---------------------------------------------------------------------
   logic                     p2_valid_ff;
   logic                     p2_op_ff;
   logic [ADDR_W-1:0]        p2_index_ff;
   texel_type                p2_texel_ff;
   logic [UV_W-1:0]          p2_u_ff, p2_v_ff;
   logic signed [POS_W-1:0]  p2_px_ff, p2_py_ff, p2_pz_ff;
   logic signed [PROD_W-1:0] u_prod_in, v_prod_in;

   always_comb begin
      u_prod_in = PROD_W'(p1_ax_ff) * PROD_W'($signed({1'b0, grid_scale_ff}));
      v_prod_in = PROD_W'(p1_az_ff) * PROD_W'($signed({1'b0, grid_scale_ff}));
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: wrap, form the four texel addresses, read the stores
   // ---------------------------------------------------------------------
   logic [XW-1:0]     ix0, ix1, iz0, iz1;
   logic [ADDR_W-1:0] addr_t1, addr_t2, addr_t3, addr_t4;
   logic              store_we;

   always_comb begin
      ix0 = p2_u_ff[FRAC_W +: XW] & WRAP;
      ix1 = (p2_u_ff[FRAC_W +: XW] + XW'(1)) & WRAP;
      iz0 = p2_v_ff[FRAC_W +: XW] & WRAP;
      iz1 = (p2_v_ff[FRAC_W +: XW] + XW'(1)) & WRAP;
      // row-major address, folded onto the store for grids above 64 x 64
      addr_t1 = ADDR_W'(32'(ix0) + 32'(iz0) * GRID_SIZE);
      addr_t2 = ADDR_W'(32'(ix1) + 32'(iz0) * GRID_SIZE);
      addr_t3 = ADDR_W'(32'(ix0) + 32'(iz1) * GRID_SIZE);
      addr_t4 = ADDR_W'(32'(ix1) + 32'(iz1) * GRID_SIZE);
      // a load writes in the same stage where samples read, so later
      // samples always see it
      store_we = advance && p2_valid_ff && (p2_op_ff == OP_LOAD);
   end

   logic [TEXEL_W-1:0] ram_near_a, ram_near_b, ram_far_a, ram_far_b;
   texel_type          tex_t1, tex_t2, tex_t3, tex_t4;

   // Two copies of the store, two read ports each: one per corner
   hbs_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_near (
      .clock     (clock),
      .wr_en     (store_we),
      .wr_addr   (p2_index_ff),
      .wr_data   (p2_texel_ff),
      .rd_en     (advance),
      .rd_addr_a (addr_t1),
      .rd_addr_b (addr_t2),
      .rd_data_a (ram_near_a),
      .rd_data_b (ram_near_b)
   );

   hbs_ram #(.WIDTH(TEXEL_W), .DEPTH(STORE_DEPTH)) u_store_far (
      .clock     (clock),
      .wr_en     (store_we),
      .wr_addr   (p2_index_ff),
      .wr_data   (p2_texel_ff),
      .rd_en     (advance),
      .rd_addr_a (addr_t3),
      .rd_addr_b (addr_t4),
      .rd_data_a (ram_far_a),
      .rd_data_b (ram_far_b)
   );

   assign tex_t1 = ram_near_a;
   assign tex_t2 = ram_near_b;
   assign tex_t3 = ram_far_a;
   assign tex_t4 = ram_far_b;

   // Stage 3: sideband next to the store read data (samples only go on)
   logic                    p3_valid_ff;
   logic                    p3_valid_in;
   logic [FRAC_W-1:0]       p3_fx_ff, p3_fz_ff;
   logic signed [POS_W-1:0] p3_px_ff, p3_py_ff, p3_pz_ff;

   assign p3_valid_in = p2_valid_ff && (p2_op_ff == OP_SAMPLE);

   // ---------------------------------------------------------------------
   // Stages 4..9: blend lanes, sideband delay line alongside
   // ---------------------------------------------------------------------
   logic signed [HEIGHT_W-1:0] blend_h;
   logic signed [SLOPE_W-1:0]  blend_sx, blend_sz;

   hbs_lerp_lane #(.DATA_W(HEIGHT_W)) u_lane_height (
      .clock     (clock),
      .enable    (advance),
      .corner_a1 (tex_t1.height),
      .corner_a2 (tex_t2.height),
      .corner_a3 (tex_t3.height),
      .corner_a4 (tex_t4.height),
      .frac_x    (p3_fx_ff),
      .frac_z    (p3_fz_ff),
      .result    (blend_h)
   );

   hbs_lerp_lane #(.DATA_W(SLOPE_W)) u_lane_slope_x (
      .clock     (clock),
      .enable    (advance),
      .corner_a1 (tex_t1.slope_x),
      .corner_a2 (tex_t2.slope_x),
      .corner_a3 (tex_t3.slope_x),
      .corner_a4 (tex_t4.slope_x),
      .frac_x    (p3_fx_ff),
      .frac_z    (p3_fz_ff),
      .result    (blend_sx)
   );

   hbs_lerp_lane #(.DATA_W(SLOPE_W)) u_lane_slope_z (
      .clock     (clock),
      .enable    (advance),
      .corner_a1 (tex_t1.slope_z),
      .corner_a2 (tex_t2.slope_z),
      .corner_a3 (tex_t3.slope_z),
      .corner_a4 (tex_t4.slope_z),
      .frac_x    (p3_fx_ff),
      .frac_z    (p3_fz_ff),
      .result    (blend_sz)
   );

   logic                    dly_valid_ff [LANE_DEPTH];
   logic signed [POS_W-1:0] dly_px_ff    [LANE_DEPTH];
   logic signed [POS_W-1:0] dly_py_ff    [LANE_DEPTH];
   logic signed [POS_W-1:0] dly_pz_ff    [LANE_DEPTH];

   // ---------------------------------------------------------------------
   // Stage 10: apply the amplitude gain
   // ---------------------------------------------------------------------
   logic                    p4_valid_ff;
   logic signed [HM_W-1:0]  p4_hm_ff;
   logic signed [SM_W-1:0]  p4_sxm_ff, p4_szm_ff;
   logic signed [POS_W-1:0] p4_px_ff, p4_py_ff, p4_pz_ff;
   logic signed [HM_W-1:0]  hm_in;
   logic signed [SM_W-1:0]  sxm_in, szm_in;

   always_comb begin
      hm_in  = HM_W'(blend_h)  * HM_W'($signed({1'b0, amplitude_ff}));
      sxm_in = SM_W'(blend_sx) * SM_W'($signed({1'b0, amplitude_ff}));
      szm_in = SM_W'(blend_sz) * SM_W'($signed({1'b0, amplitude_ff}));
   end

   // ---------------------------------------------------------------------
   // Stage 11: displace, saturate, pack the normal codes
   // ---------------------------------------------------------------------
   function automatic logic [CODE_W-1:0] slope_code(input logic signed [SM_W-1:0] m);
      logic signed [CS_W-1:0] c;
      logic [CODE_W-1:0]      code;
      c = CS_W'(m >>> FRAC_W) + CS_W'(1024);
      if (c < 0) begin
         code = '0;
      end else if (c > 2047) begin
         code = '1;
      end else begin
         code = c[CODE_W-1:0];
      end
      return code;
   endfunction

   logic signed [YS_W-1:0]  y_sum;
   logic                    y_over;
   logic [CODE_W-1:0]       code_x, code_z;
   rsp_item_type            rsp_item_in;

   always_comb begin
      y_sum  = YS_W'(p4_py_ff) + YS_W'(p4_hm_ff >>> 12);
      // out of range when the bits above the sign do not all match it
      y_over = !((&y_sum[YS_W-1:POS_W-1]) || !(|y_sum[YS_W-1:POS_W-1]));
      code_x = slope_code(p4_sxm_ff);
      code_z = slope_code(p4_szm_ff);

      rsp_item_in.out_x = p4_px_ff;
      rsp_item_in.out_z = p4_pz_ff;
      if (y_over) begin
         rsp_item_in.out_y = y_sum[YS_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                           : {1'b0, {(POS_W-1){1'b1}}};
      end else begin
         rsp_item_in.out_y = y_sum[POS_W-1:0];
      end
      rsp_item_in.normal_word = ({5'b0, code_z, 5'b0, code_x}) | alpha_bits_ff;
   end

   // ---------------------------------------------------------------------
   // Valid bits (reset) and payload registers (no reset)
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LANE_DEPTH; i++) begin
            dly_valid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         p1_valid_ff     <= req_chan.valid;
         p2_valid_ff     <= p1_valid_ff;
         p3_valid_ff     <= p3_valid_in;
         dly_valid_ff[0] <= p3_valid_ff;
         for (int i = 1; i < LANE_DEPTH; i++) begin
            dly_valid_ff[i] <= dly_valid_ff[i-1];
         end
         p4_valid_ff     <= dly_valid_ff[LANE_DEPTH-1];
         rsp_valid_ff    <= p4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_op_ff            <= req_chan.payload.opcode;
         p1_index_ff         <= req_chan.payload.texel_index;
         p1_texel_ff.height  <= req_chan.payload.texel_height;
         p1_texel_ff.slope_x <= req_chan.payload.texel_slope_x;
         p1_texel_ff.slope_z <= req_chan.payload.texel_slope_z;
         p1_ax_ff            <= SUM_W'(req_chan.payload.pos_x) + SUM_W'(move_x_ff);
         p1_az_ff            <= SUM_W'(req_chan.payload.pos_z) + SUM_W'(move_z_ff);
         p1_px_ff            <= req_chan.payload.pos_x;
         p1_py_ff            <= req_chan.payload.pos_y;
         p1_pz_ff            <= req_chan.payload.pos_z;

         p2_op_ff    <= p1_op_ff;
         p2_index_ff <= p1_index_ff;
         p2_texel_ff <= p1_texel_ff;
         p2_u_ff     <= u_prod_in[FRAC_W +: UV_W];
         p2_v_ff     <= v_prod_in[FRAC_W +: UV_W];
         p2_px_ff    <= p1_px_ff;
         p2_py_ff    <= p1_py_ff;
         p2_pz_ff    <= p1_pz_ff;

         p3_fx_ff <= p2_u_ff[FRAC_W-1:0];
         p3_fz_ff <= p2_v_ff[FRAC_W-1:0];
         p3_px_ff <= p2_px_ff;
         p3_py_ff <= p2_py_ff;
         p3_pz_ff <= p2_pz_ff;

         dly_px_ff[0] <= p3_px_ff;
         dly_py_ff[0] <= p3_py_ff;
         dly_pz_ff[0] <= p3_pz_ff;
         for (int i = 1; i < LANE_DEPTH; i++) begin
            dly_px_ff[i] <= dly_px_ff[i-1];
            dly_py_ff[i] <= dly_py_ff[i-1];
            dly_pz_ff[i] <= dly_pz_ff[i-1];
         end

         p4_hm_ff  <= hm_in;
         p4_sxm_ff <= sxm_in;
         p4_szm_ff <= szm_in;
         p4_px_ff  <= dly_px_ff[LANE_DEPTH-1];
         p4_py_ff  <= dly_py_ff[LANE_DEPTH-1];
         p4_pz_ff  <= dly_pz_ff[LANE_DEPTH-1];

         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_load_drops: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && (p2_op_ff == OP_LOAD) && advance |=> !p3_valid_ff)
      else $error("load item went past the store stage");

   a_sample_kept: assert property (@(posedge clock) disable iff (reset)
      p2_valid_ff && (p2_op_ff == OP_SAMPLE) && advance |=> p3_valid_ff)
      else $error("sample item lost at the store stage");

   a_lane_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(dly_valid_ff[LANE_DEPTH-1]) && $stable(p4_valid_ff))
      else $error("blend stage moved during a hold");

   a_code_gaps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         ((rsp_item_ff.normal_word & ~alpha_bits_ff) & UNUSED_CODE_BITS) == '0)
      else $error("normal code spilled outside its 11-bit field");

endmodule

`default_nettype wire

>>> dv/wrapped_bilinear_heightfield_sampler_unit_tb.sv
`timescale 1ns / 1ps

module wrapped_bilinear_heightfield_sampler_unit_tb;
   import hbs_pkg::*;

   localparam int GRID            = GRID_SIZE_DEF;
   localparam int IDLE_PCT        = 31;
   localparam int STALL_LIMIT     = 4000;
   // Pipeline is 11 deep; give loads still in flight some margin.
   localparam int SETTLE_CYCLES   = 24;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 230;

   // Indexes past the register list: the block must drop these writes.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;

   localparam longint Y_MAX = 64'sd2147483647;
   localparam longint Y_MIN = -64'sd2147483648;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   hbs_req_if req_chan ();
   hbs_rsp_if rsp_chan ();

   wrapped_bilinear_heightfield_sampler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the configuration, as the block should hold it.
   logic signed [POS_W-1:0] cur_move_x;
   logic signed [POS_W-1:0] cur_move_z;
   logic [SCALE_W-1:0]      cur_scale;
   logic [AMP_W-1:0]        cur_amp;
   logic [WORD_W-1:0]       cur_alpha;

   // Shadow texel stores, updated when a load item is taken.
   logic signed [HEIGHT_W-1:0] height_mem  [STORE_DEPTH];
   logic signed [SLOPE_W-1:0]  slope_x_mem [STORE_DEPTH];
   logic signed [SLOPE_W-1:0]  slope_z_mem [STORE_DEPTH];

   // Texels that some queued load will have written by the time a later
   // sample is taken; keeps every sample off never-written entries.
   bit loaded_plan [STORE_DEPTH];

   req_item_type req_backlog [$];
   rsp_item_type displaced_q [$];

   int unsigned items_queued;
   int unsigned items_taken;
   int unsigned stall_cycles;
   int          errors;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Arithmetic of the sampler
   // ---------------------------------------------------------------------

   // Position to texel space: exact product, 32-bit fraction.
   function automatic logic [63:0] to_texel(logic signed [POS_W-1:0] pos,
                                            logic signed [POS_W-1:0] offs);
      longint sum;
      sum = longint'(pos) + longint'(offs);
      return sum * longint'(cur_scale);
   endfunction

   // Store address of one of the four neighbors: bit 0 of k steps x, bit 1
   // steps z. Integer parts wrap by the grid size, the address by the store.
   function automatic logic [ADDR_W-1:0] corner_addr(logic [63:0] u, logic [63:0] v,
                                                     int k);
      logic [63:0] ix;
      logic [63:0] iz;
      ix = ((u >> 32) + (k & 1)) & (GRID - 1);
      iz = ((v >> 32) + (k >> 1)) & (GRID - 1);
      return ADDR_W'((ix + iz * GRID) & (STORE_DEPTH - 1));
   endfunction

   // Weighted sum over Q0.32 weights, floored back to the texel scale.
   function automatic longint blend(longint a1, longint a2, longint a3, longint a4,
                                    longint fx, longint fz);
      longint gx;
      longint gz;
      longint acc;
      gx  = 65536 - fx;
      gz  = 65536 - fz;
      acc = a1 * (gx * gz) + a2 * (fx * gz) + a3 * (gx * fz) + a4 * (fx * fz);
      return acc >>> 32;
   endfunction

   function automatic logic [CODE_W-1:0] slope_code(longint s, longint amp);
      longint c;
      c = ((s * amp) >>> 16) + 1024;
      if (c < 0)
         c = 0;
      if (c > 2047)
         c = 2047;
      return CODE_W'(c);
   endfunction

   function automatic rsp_item_type displace_sample(req_item_type it);
      logic [63:0]       u;
      logic [63:0]       v;
      logic [ADDR_W-1:0] t;
      longint            h [4];
      longint            sx [4];
      longint            sz [4];
      longint            fx;
      longint            fz;
      longint            amp;
      longint            y;
      int                k;
      rsp_item_type      r;
      u  = to_texel(it.pos_x, cur_move_x);
      v  = to_texel(it.pos_z, cur_move_z);
      fx = longint'(u[31:16]);
      fz = longint'(v[31:16]);
      for (k = 0; k < 4; k++) begin
         t     = corner_addr(u, v, k);
         h[k]  = longint'(height_mem[t]);
         sx[k] = longint'(slope_x_mem[t]);
         sz[k] = longint'(slope_z_mem[t]);
      end
      amp = longint'(cur_amp);
      y   = longint'($signed(it.pos_y))
            + ((blend(h[0], h[1], h[2], h[3], fx, fz) * amp) >>> 12);
      if (y > Y_MAX)
         y = Y_MAX;
      if (y < Y_MIN)
         y = Y_MIN;
      r.out_x       = it.pos_x;
      r.out_y       = y[31:0];
      r.out_z       = it.pos_z;
      r.normal_word = (32'(slope_code(blend(sz[0], sz[1], sz[2], sz[3], fx, fz), amp)) << 16)
                      | 32'(slope_code(blend(sx[0], sx[1], sx[2], sx[3], fx, fz), amp))
                      | cur_alpha;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Random word that lands on the edges of the range now and then.
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Fill every field, including the ones the opcode leaves unused.
   function automatic req_item_type noise_item();
      req_item_type it;
      it.opcode        = 1'($urandom);
      it.texel_index   = ADDR_W'($urandom);
      it.texel_height  = pick32();
      it.texel_slope_x = pick16();
      it.texel_slope_z = pick16();
      it.pos_x         = pick32();
      it.pos_y         = pick32();
      it.pos_z         = pick32();
      return it;
   endfunction

   task automatic queue_item(req_item_type it);
      req_backlog.push_back(it);
      items_queued++;
   endtask

   task automatic queue_load(logic [ADDR_W-1:0] a, logic [31:0] h, logic [15:0] sx,
                             logic [15:0] sz);
      req_item_type it;
      it               = noise_item();
      it.opcode        = OP_LOAD;
      it.texel_index   = a;
      it.texel_height  = h;
      it.texel_slope_x = sx;
      it.texel_slope_z = sz;
      loaded_plan[a]   = 1'b1;
      queue_item(it);
   endtask

   // Precede the sample with loads of any neighbor not written yet.
   task automatic queue_sample(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
      req_item_type      it;
      logic [63:0]       u;
      logic [63:0]       v;
      logic [ADDR_W-1:0] a;
      int                k;
      u = to_texel(px, cur_move_x);
      v = to_texel(pz, cur_move_z);
      for (k = 0; k < 4; k++) begin
         a = corner_addr(u, v, k);
         if (!loaded_plan[a])
            queue_load(a, pick32(), pick16(), pick16());
      end
      it        = noise_item();
      it.opcode = OP_SAMPLE;
      it.pos_x  = px;
      it.pos_y  = py;
      it.pos_z  = pz;
      queue_item(it);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write all registers back to back, then one write the block must ignore.
   // Junk in the bits above a narrow register checks that they are dropped.
   task automatic apply_config(logic [31:0] mx, logic [31:0] mz, logic [SCALE_W-1:0] sc,
                               logic [AMP_W-1:0] am, logic [WORD_W-1:0] al);
      write_csr(CSR_MOVE_X, mx);
      write_csr(CSR_MOVE_Z, mz);
      write_csr(CSR_GRID_SCALE, {8'($urandom), sc});
      write_csr(CSR_AMPLITUDE, {16'($urandom), am});
      write_csr(CSR_ALPHA_BITS, al);
      write_csr(CSR_SPARE_FIRST + 3'($urandom_range(0, 2)), $urandom);
      @(posedge clock);
      csr_we     <= 1'b0;
      cur_move_x = mx;
      cur_move_z = mz;
      cur_scale  = sc;
      cur_amp    = am;
      cur_alpha  = al;
   endtask

   // Hold until every item is taken and every result is back, then let the
   // pipeline run empty so no load is still on its way to the stores.
   task automatic wait_idle();
      while (items_taken != items_queued || displaced_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: takes items from the backlog, idles at random, and
   // updates the shadow model when an item is taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      req_item_type taken;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            taken = req_chan.payload;
            if (taken.opcode == OP_LOAD) begin
               height_mem[taken.texel_index]  = taken.texel_height;
               slope_x_mem[taken.texel_index] = taken.texel_slope_x;
               slope_z_mem[taken.texel_index] = taken.texel_slope_z;
            end else begin
               displaced_q.push_back(displace_sample(taken));
            end
            items_taken++;
         end
         // Advance only when the slot is free or just drained.
         if (!req_chan.valid || req_chan.ready) begin
            if (req_backlog.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_chan.payload <= req_backlog.pop_front();
               req_chan.valid   <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result monitor: stalls at random, checks each taken result against the
   // oldest expectation.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      rsp_item_type got;
      rsp_item_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (displaced_q.size() == 0) begin
               $error("result item with nothing expected: out_x %h out_y %h", got.out_x,
                      got.out_y);
               errors++;
            end else begin
               want = displaced_q.pop_front();
               if (got.out_x !== want.out_x) begin
                  $error("out_x: expected %h, got %h", want.out_x, got.out_x);
                  errors++;
               end
               if (got.out_y !== want.out_y) begin
                  $error("out_y: expected %h, got %h", want.out_y, got.out_y);
                  errors++;
               end
               if (got.out_z !== want.out_z) begin
                  $error("out_z: expected %h, got %h", want.out_z, got.out_z);
                  errors++;
               end
               if (got.normal_word !== want.normal_word) begin
                  $error("normal_word: expected %h, got %h", want.normal_word,
                         got.normal_word);
                  errors++;
               end
            end
         end
         rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Drop the run if neither channel moves an item for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence: directed items at reset settings, then phases of random
   // items, each under its own configuration written while idle.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int          p;
      int unsigned phase_mark;
      logic [31:0] px;
      logic [31:0] pz;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      reset            = 1'b1;
      no_idle          = 1'b0;
      errors           = 0;
      items_queued     = 0;
      items_taken      = 0;
      stall_cycles     = 0;
      cur_move_x       = '0;
      cur_move_z       = '0;
      cur_scale        = GRID_SCALE_RST;
      cur_amp          = AMPLITUDE_RST;
      cur_alpha        = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Texels at and next to the grid corners, some with the extreme values.
      queue_load(12'd0, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF);
      queue_load(12'd1, 32'h8000_0000, 16'h8000, 16'h8000);
      queue_load(12'd64, 32'h0000_0000, 16'h0000, 16'h0000);
      queue_load(12'd65, 32'hFFFF_FFFF, 16'hFFFF, 16'h0001);
      queue_load(12'd63, 32'h0001_8000, 16'h2000, 16'hE000);
      queue_load(12'd4032, 32'hFFFE_0000, 16'h4000, 16'hC000);
      queue_load(12'd4095, 32'h0003_0000, 16'h1234, 16'hEDCC);
      // Whole weight on one texel; the positive slope codes saturate high.
      queue_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      // Base height plus the largest height overflows upward.
      queue_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
      // Lowest height on the lowest base overflows downward; codes clamp at 0.
      queue_sample(32'h0001_0000, 32'h8000_0000, 32'h0000_0000);
      queue_sample(32'h0000_8000, 32'h0000_0000, 32'h0000_8000);
      // Negative position wraps to the far edge of the grid.
      queue_sample(32'hFFFF_8000, 32'h1234_5678, 32'hFFFF_8000);
      // Last texel with a nearly full fraction wraps its neighbors to 0.
      queue_sample(32'h003F_FFFF, 32'h0000_0000, 32'h003F_FFFF);
      queue_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      queue_sample(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
      // Rewrite a texel and read it back right behind the load.
      queue_load(12'd0, 32'h0000_0000, 16'h0000, 16'h0000);
      queue_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);

      for (p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_idle();
            case (p)
               1: apply_config(pick32(), pick32(), SCALE_W'($urandom), AMP_W'($urandom),
                               $urandom);
               2: apply_config(32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 16'hFFFF,
                               32'hFFFF_FFFF);
               3: apply_config(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000, 16'h0000,
                               32'h0000_0000);
               4: apply_config(32'($urandom_range(0, 32'h0040_0000)), $urandom,
                               SCALE_W'($urandom_range(1, 32'h4000)),
                               AMP_W'($urandom_range(2048, 8192)), $urandom);
               default: apply_config(pick32(), pick32(),
                                     $urandom_range(0, 1) ? SCALE_W'($urandom_range(0, 32'h3_0000))
                                                          : SCALE_W'($urandom),
                                     $urandom_range(0, 1) ? AMP_W'($urandom_range(0, 16384))
                                                          : pick16(),
                                     pick32());
            endcase
         end
         // One phase runs with both sides always ready.
         no_idle    = (p == 4);
         phase_mark = items_queued;
         while (items_queued - phase_mark < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 20) begin
               queue_load(ADDR_W'($urandom), pick32(), pick16(), pick16());
            end else begin
               case ($urandom_range(0, 2))
                  0: begin
                     px = pick32();
                     pz = pick32();
                  end
                  1: begin
                     // Stay near the origin so texels are shared between samples.
                     px = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
                     pz = $urandom_range(0, 32'h01FF_FFFF) - 32'h0100_0000;
                  end
                  default: begin
                     // Sit on or just below a texel boundary.
                     px = {16'($urandom_range(0, 255) - 128),
                           $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
                     pz = {16'($urandom_range(0, 255) - 128),
                           $urandom_range(0, 1) ? 16'hFFFF : 16'h0000};
                  end
               endcase
               queue_sample(px, pick32(), pz);
            end
         end
      end

      wait_idle();
      if (errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
